// ----- sv/bafp_pkg.sv -----
// shared types, constants and helpers of the bit-aligned field packer
package bafp_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int BYTE_AW      = $clog2(BUFFER_BYTES);
    localparam int WORD_AW      = BYTE_AW - 2;
    localparam int ROW_AW       = WORD_AW - 1;
    localparam int POS_W        = BYTE_AW + 3;
    localparam int CURSOR_W     = 14;
    localparam int PB_W         = 11;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CURSOR_W-1:0] HEADER_BITS = CURSOR_W'(32);
    localparam logic [PB_W-1:0]     PB_RESET    = PB_W'(1024);

    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_PUT    = 3'd1;
    localparam logic [2:0] ACT_LENGTH = 3'd2;
    localparam logic [2:0] ACT_REWIND = 3'd3;
    localparam logic [2:0] ACT_GET    = 3'd4;
    localparam logic [2:0] ACT_LOAD   = 3'd5;
    localparam logic [2:0] ACT_FETCH  = 3'd6;

    localparam logic [1:0] WC_ONE   = 2'd0;
    localparam logic [1:0] WC_EIGHT = 2'd1;
    localparam logic [1:0] WC_SIXTN = 2'd2;
    localparam logic [1:0] WC_WORD  = 2'd3;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CLEAR,
        OP_PUT,
        OP_GET,
        OP_LOAD,
        OP_FETCH
    } op_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_WRITE
    } back_state_t;

    typedef struct packed {
        op_t                 op;
        logic [POS_W-1:0]    pos;
        logic [1:0]          width_code;
        logic                sign_extend;
        logic [31:0]         value;
        logic [BYTE_AW-1:0]  byte_address;
        logic [7:0]          byte_value;
        logic                status;
        logic [CURSOR_W-1:0] cursor;
    } entry_t;

    function automatic logic [5:0] width_bits(input logic [1:0] code);
        logic [5:0] w;
        unique case (code)
            WC_ONE:   w = 6'd1;
            WC_EIGHT: w = 6'd8;
            WC_SIXTN: w = 6'd16;
            default:  w = 6'd32;
        endcase
        return w;
    endfunction

endpackage

// ----- sv/bafp_ifs.sv -----
// request and response channel interfaces
interface bafp_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [1:0]  width_code;
    logic        sign_extend;
    logic [31:0] field_value;
    logic [9:0]  byte_address;
    logic [7:0]  byte_value;
    modport source (output valid, action, width_code, sign_extend, field_value,
                    byte_address, byte_value, input ready);
    modport sink (input valid, action, width_code, sign_extend, field_value,
                  byte_address, byte_value, output ready);
endinterface

interface bafp_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [7:0]  read_byte;
    logic        status;
    logic [13:0] cursor_out;
    modport source (output valid, read_value, read_byte, status, cursor_out, input ready);
    modport sink (input valid, read_value, read_byte, status, cursor_out, output ready);
endinterface

// ----- sv/bafp_front.sv -----
// front end: accepts words, tracks the cursor and size limit, classifies
module bafp_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [10:0]               cfg_wdata,
    bafp_req_if.sink                  req,
    input  logic                      hold,
    output logic                      push,
    output bafp_pkg::entry_t          push_entry
);
    import bafp_pkg::*;

    logic [PB_W-1:0]     packet_bytes_reg;
    logic [CURSOR_W-1:0] cursor_reg;
    logic [CURSOR_W-1:0] cursor_next;
    logic [PB_W-1:0]     pb_lim;
    logic [CURSOR_W-1:0] limit_bits;
    logic [5:0]          w;
    logic [CURSOR_W:0]   sum;
    logic                fits;
    entry_t              e;

    assign req.ready = !hold;
    assign push      = req.valid && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_bytes_reg <= PB_RESET;
            cursor_reg       <= HEADER_BITS;
        end
        else
        begin
            if (cfg_we)
            begin
                packet_bytes_reg <= cfg_wdata;
            end
            if (push)
            begin
                cursor_reg <= cursor_next;
            end
        end
    end

    always_comb
    begin
        pb_lim     = (packet_bytes_reg > PB_W'(BUFFER_BYTES)) ? PB_W'(BUFFER_BYTES)
                                                              : packet_bytes_reg;
        limit_bits = {pb_lim, 3'b000};
        w          = width_bits(req.width_code);
        sum        = {1'b0, cursor_reg} + (CURSOR_W + 1)'(w);
        fits       = sum <= {1'b0, limit_bits};

        cursor_next    = cursor_reg;
        e.op           = OP_NONE;
        e.pos          = cursor_reg[POS_W-1:0];
        e.width_code   = req.width_code;
        e.sign_extend  = req.sign_extend;
        e.value        = req.field_value;
        e.byte_address = req.byte_address;
        e.byte_value   = req.byte_value;
        e.status       = 1'b0;

        unique case (req.action)
            ACT_CLEAR:
            begin
                e.op        = OP_CLEAR;
                cursor_next = HEADER_BITS;
            end
            ACT_PUT:
            begin
                if (fits)
                begin
                    e.op        = OP_PUT;
                    cursor_next = sum[CURSOR_W-1:0];
                end
                else
                begin
                    e.status = 1'b1;
                end
            end
            ACT_LENGTH:
            begin
                if (limit_bits >= HEADER_BITS)
                begin
                    e.op         = OP_PUT;
                    e.pos        = '0;
                    e.width_code = WC_WORD;
                    e.value      = 32'({cursor_reg[CURSOR_W-1:3]});
                end
                else
                begin
                    e.status = 1'b1;
                end
            end
            ACT_REWIND:
            begin
                cursor_next = '0;
            end
            ACT_GET:
            begin
                if (fits)
                begin
                    e.op        = OP_GET;
                    cursor_next = sum[CURSOR_W-1:0];
                end
                else
                begin
                    e.status = 1'b1;
                end
            end
            ACT_LOAD:  e.op = OP_LOAD;
            ACT_FETCH: e.op = OP_FETCH;
            default:   e.op = OP_NONE;
        endcase
        e.cursor   = cursor_next;
        push_entry = e;
    end
endmodule

// ----- sv/bafp_fifo.sv -----
// short queue between front and back
module bafp_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bafp_pkg::entry_t push_entry,
    input  logic             pop,
    output bafp_pkg::entry_t head,
    output logic             full,
    output logic             empty
);
    import bafp_pkg::*;

    entry_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end
endmodule

// ----- sv/bafp_back.sv -----
// back end: two-bank buffer memory, read-modify-write sequencer, result register
module bafp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  bafp_pkg::entry_t head,
    input  logic             empty,
    output logic             pop,
    output logic             init_busy,
    bafp_rsp_if.source       rsp
);
    import bafp_pkg::*;

    localparam int ROWS = BUFFER_BYTES / 8;

    logic [31:0] mem_even [ROWS];
    logic [31:0] mem_odd  [ROWS];

    back_state_t       state_reg, state_next;
    entry_t            cur_reg, cur_next;
    logic [ROW_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              init_reg, init_next;
    logic [31:0]       rd_even_reg, rd_odd_reg;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       read_value_reg;
    logic [7:0]        read_byte_reg;
    logic              status_reg;
    logic [13:0]       cursor_out_reg;

    logic              byte_op;
    logic [WORD_AW-1:0] wi;
    logic [ROW_AW-1:0] row_a, even_addr, odd_addr;
    logic              second_out;
    logic [4:0]        off;
    logic [31:0]       first, second, lj, top, new_first, new_second;
    logic [63:0]       win, put_win, taken;
    logic [31:0]       rv;
    logic [7:0]        rb;
    logic              sx;
    logic              out_free, wr_go;
    logic              we_even, we_odd;
    logic [31:0]       wd_even, wd_odd;

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.read_byte  = read_byte_reg;
    assign rsp.status     = status_reg;
    assign rsp.cursor_out = cursor_out_reg;
    assign init_busy      = init_reg;

    always_comb
    begin
        byte_op    = cur_reg.op == OP_LOAD || cur_reg.op == OP_FETCH;
        wi         = byte_op ? cur_reg.byte_address[BYTE_AW-1:2] : cur_reg.pos[POS_W-1:5];
        row_a      = wi[WORD_AW-1:1];
        second_out = wi[0] && (row_a == '1);
        off        = byte_op ? {cur_reg.byte_address[1:0], 3'b000} : cur_reg.pos[4:0];

        first  = wi[0] ? rd_odd_reg : rd_even_reg;
        second = wi[0] ? (second_out ? 32'h0 : rd_even_reg) : rd_odd_reg;
        win    = {first, second};

        case (cur_reg.width_code)
            WC_ONE:   lj = {cur_reg.value[0], 31'h0};
            WC_EIGHT: lj = {cur_reg.value[7:0], 24'h0};
            WC_SIXTN: lj = {cur_reg.value[15:0], 16'h0};
            default:  lj = cur_reg.value;
        endcase
        put_win = win | ({lj, 32'h0} >> off);

        taken = win << off;
        top   = taken[63:32];
        sx    = cur_reg.sign_extend && top[31];
        case (cur_reg.width_code)
            WC_ONE:   rv = {{31{sx}}, top[31]};
            WC_EIGHT: rv = {{24{sx}}, top[31:24]};
            WC_SIXTN: rv = {{16{sx}}, top[31:16]};
            default:  rv = top;
        endcase

        new_first  = first;
        new_second = second;
        rb         = 8'h0;
        case (cur_reg.byte_address[1:0])
            2'd0:    rb = first[31:24];
            2'd1:    rb = first[23:16];
            2'd2:    rb = first[15:8];
            default: rb = first[7:0];
        endcase
        if (cur_reg.op == OP_PUT)
        begin
            new_first  = put_win[63:32];
            new_second = put_win[31:0];
        end
        else if (cur_reg.op == OP_LOAD)
        begin
            case (cur_reg.byte_address[1:0])
                2'd0:    new_first[31:24] = cur_reg.byte_value;
                2'd1:    new_first[23:16] = cur_reg.byte_value;
                2'd2:    new_first[15:8]  = cur_reg.byte_value;
                default: new_first[7:0]   = cur_reg.byte_value;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        clr_cnt_next   = clr_cnt_reg;
        init_next      = init_reg;
        pop            = 1'b0;
        out_free       = !out_valid_reg || rsp.ready;
        wr_go          = 1'b0;
        out_valid_next = out_valid_reg && !rsp.ready;
        even_addr      = wi[0] ? row_a + 1'b1 : row_a;
        odd_addr       = row_a;
        we_even        = 1'b0;
        we_odd         = 1'b0;
        wd_even        = wi[0] ? new_second : new_first;
        wd_odd         = wi[0] ? new_first : new_second;

        unique case (state_reg)
            B_CLEAR:
            begin
                even_addr    = clr_cnt_reg;
                odd_addr     = clr_cnt_reg;
                we_even      = 1'b1;
                we_odd       = 1'b1;
                wd_even      = '0;
                wd_odd       = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    init_next  = 1'b0;
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_WRITE;
            end
            B_WRITE:
            begin
                if (out_free)
                begin
                    wr_go          = 1'b1;
                    out_valid_next = 1'b1;
                    if (cur_reg.op == OP_PUT || cur_reg.op == OP_LOAD)
                    begin
                        we_odd  = 1'b1;
                        we_even = !second_out;
                    end
                    if (cur_reg.op == OP_CLEAR)
                    begin
                        state_next = B_CLEAR;
                    end
                    else if (!empty)
                    begin
                        pop        = 1'b1;
                        cur_next   = head;
                        state_next = B_READ;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (wr_go)
        begin
            read_value_reg <= (cur_reg.op == OP_GET) ? rv : 32'h0;
            read_byte_reg  <= (cur_reg.op == OP_FETCH) ? rb : 8'h0;
            status_reg     <= cur_reg.status;
            cursor_out_reg <= cur_reg.cursor;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_even_reg <= mem_even[even_addr];
        if (we_even)
        begin
            mem_even[even_addr] <= wd_even;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_odd_reg <= mem_odd[odd_addr];
        if (we_odd)
        begin
            mem_odd[odd_addr] <= wd_odd;
        end
    end
endmodule

// ----- sv/bit_aligned_field_packer_unit.sv -----
// top level of the bit-aligned field packer
// The back end reads the two buffer words around the bit cursor from the even and
// odd banks in a read state; a write state, stalled while a held result is not
// taken, writes them back merged for a put or load and loads the result register.
// The front end keeps the cursor and accepts up to 2 words ahead in the queue. A
// clear word adds a zeroing pass over the 128 memory rows; after reset this pass
// runs and no word is accepted until it ends. Results come in request order.
module bit_aligned_field_packer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata,
    bafp_req_if.sink    req,
    bafp_rsp_if.source  rsp
);
    import bafp_pkg::*;

    entry_t push_entry, head;
    logic   push, pop, full, empty, init_busy;

    bafp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req),
        .hold       (full || init_busy),
        .push       (push),
        .push_entry (push_entry)
    );

    bafp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    bafp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .init_busy (init_busy),
        .rsp       (rsp)
    );
endmodule

// ----- sv/bafp_checker.sv -----
// port-level checks of the packer, bound to the top level
module bafp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] read_value,
    input logic [7:0]  read_byte,
    input logic        status,
    input logic [13:0] cursor_out
);
    a_refused_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status |-> read_value == 32'h0 && read_byte == 8'h0)
        else $error("refused word carries data");

    a_one_data_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_byte != 8'h0 |-> read_value == 32'h0)
        else $error("fetch and get data both set");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> cursor_out <= 14'd8192)
        else $error("cursor past buffer end");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(cursor_out))
        else $error("stalled result changed");
endmodule

bind bit_aligned_field_packer_unit bafp_checker u_bafp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .read_value (rsp.read_value),
    .read_byte  (rsp.read_byte),
    .status     (rsp.status),
    .cursor_out (rsp.cursor_out)
);
